[hw/rtl/sonar_serial_depth_parser_assert.svh]
// Assertion macros for the depth parser.
`ifndef SONAR_SERIAL_DEPTH_PARSER_ASSERT_SVH
`define SONAR_SERIAL_DEPTH_PARSER_ASSERT_SVH

// Same-cycle implication, checked out of reset.
`define SDP_ASSERT_NOW(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error("sdp assertion failed");

// Next-cycle implication, checked out of reset.
`define SDP_ASSERT_NEXT(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error("sdp assertion failed");

`endif

[hw/rtl/sdp_pkg.sv]
package sdp_pkg;

    typedef enum logic [1:0] {
        ACT_START  = 2'd0,
        ACT_BYTE   = 2'd1,
        ACT_REPORT = 2'd2
    } action_t;

    typedef enum logic [1:0] {
        ERR_NONE       = 2'd0,
        ERR_NO_READING = 2'd1,
        ERR_MODEL      = 2'd2
    } err_t;

    typedef enum logic [1:0] {
        KIND_UNKNOWN = 2'd0,
        KIND_SHORT   = 2'd1,
        KIND_LONG    = 2'd2
    } kind_t;

    typedef enum logic [1:0] {
        PH_SEARCH  = 2'd0,
        PH_CAPTURE = 2'd1,
        PH_DONE    = 2'd2
    } phase_t;

    localparam int unsigned CAP_MAX = 4;

    typedef logic [0:7][7:0]         marker_t;
    typedef logic [0:CAP_MAX-1][7:0] chars4_t;

    typedef struct packed {
        logic       done;
        chars4_t    chars;
        logic [2:0] len;
    } trk_status_t;

    localparam logic [7:0] CR_CHAR = 8'h0D;

    localparam marker_t    READ_MARKER  = {"T", "e", "m", "p", "I", CR_CHAR, "R", 8'h00};
    localparam logic [2:0] READ_MARK_LEN = 3'd7;
    localparam marker_t    MODEL_MARKER = {"P", "N", ":", "M", "B", 8'h00, 8'h00, 8'h00};
    localparam logic [2:0] MODEL_MARK_LEN = 3'd5;

    localparam chars4_t MODEL_SHORT  = "7384";
    localparam chars4_t MODEL_LONG   = "7383";
    localparam chars4_t SENTINEL_SHORT = "5000";
    localparam chars4_t SENTINEL_LONG  = "9999";

    function automatic logic match4(chars4_t chars, logic [2:0] len, chars4_t ref_str);
        return (len == 3'(CAP_MAX)) && (chars == ref_str);
    endfunction

endpackage

[hw/rtl/sdp_tracker.sv]
module sdp_tracker (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                clear,
    input  logic                step,
    input  logic [7:0]          rx_byte,
    input  sdp_pkg::marker_t    marker,
    input  logic [2:0]          marker_len,
    output sdp_pkg::trk_status_t status
);
    import sdp_pkg::*;

    phase_t     phase_reg, phase_next;
    logic [2:0] pos_reg, pos_next;
    logic [2:0] len_reg, len_next;
    chars4_t    chars_reg, chars_next;

    logic [2:0] pos_adv;

    always_comb begin
        phase_next = phase_reg;
        pos_next   = pos_reg;
        len_next   = len_reg;
        chars_next = chars_reg;
        pos_adv    = pos_reg;
        if (clear) begin
            phase_next = PH_SEARCH;
            pos_next   = 3'd0;
            len_next   = 3'd0;
        end else if (step) begin
            case (phase_reg)
                PH_SEARCH: begin
                    if ((pos_reg < marker_len) && (rx_byte == marker[pos_reg])) begin
                        pos_adv = pos_reg + 3'd1;
                    end else begin
                        // first marker char never repeats inside the marker
                        pos_adv = (rx_byte == marker[0]) ? 3'd1 : 3'd0;
                    end
                    if (pos_adv >= marker_len) begin
                        phase_next = PH_CAPTURE;
                        pos_next   = 3'd0;
                    end else begin
                        pos_next = pos_adv;
                    end
                end
                PH_CAPTURE: begin
                    if (rx_byte == CR_CHAR) begin
                        phase_next = PH_DONE;
                    end else if (len_reg < 3'(CAP_MAX)) begin
                        chars_next[len_reg[1:0]] = rx_byte;
                        len_next = len_reg + 3'd1;
                    end
                end
                default: begin
                end
            endcase
        end
    end

    always_comb begin
        status.done  = (phase_reg == PH_DONE);
        status.chars = chars_reg;
        status.len   = len_reg;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg <= PH_SEARCH;
            pos_reg   <= 3'd0;
            len_reg   <= 3'd0;
        end else begin
            phase_reg <= phase_next;
            pos_reg   <= pos_next;
            len_reg   <= len_next;
        end
        chars_reg <= chars_next;
    end

endmodule

[hw/rtl/sonar_serial_depth_parser.sv]
// An accepted beat is held in the input register and processed from there; a report
// passes from the input register to the result register, which drives m_valid.
// Throughput: one beat per cycle; only a report beat waits, in the input
// register, while the result register holds an untaken report.
// Reset: synchronous active-low aresetn clears both marker trackers and the
// handshake state; no clearing pass.
module sonar_serial_depth_parser (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [1:0]  s_action,
    input  logic [7:0]  s_rx_byte,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [13:0] m_depth_mm,
    output logic [1:0]  m_error_code,
    output logic [1:0]  m_model_kind
);
    import sdp_pkg::*;

    logic       in_valid_reg, in_valid_next;
    action_t    in_action_reg;
    logic [7:0] in_byte_reg;

    logic        m_valid_reg, m_valid_next;
    logic [13:0] depth_reg;
    err_t        err_reg;
    kind_t       kind_reg;

    logic slot_free, fire, out_load, trk_clear, trk_step;
    trk_status_t rd_status, md_status;

    logic [13:0] depth_val;
    err_t        err_val;
    kind_t       kind_val;
    logic        digit_run;
    logic [7:0]  c;

    assign slot_free = !m_valid_reg || m_ready;
    assign fire      = in_valid_reg && ((in_action_reg != ACT_REPORT) || slot_free);
    assign s_ready   = !in_valid_reg || fire;
    assign out_load  = fire && (in_action_reg == ACT_REPORT);
    assign trk_clear = fire && (in_action_reg == ACT_START);
    assign trk_step  = fire && (in_action_reg == ACT_BYTE) && (in_byte_reg != 8'd0);

    sdp_tracker u_reading (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .clear      (trk_clear),
        .step       (trk_step),
        .rx_byte    (in_byte_reg),
        .marker     (READ_MARKER),
        .marker_len (READ_MARK_LEN),
        .status     (rd_status)
    );

    sdp_tracker u_model (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .clear      (trk_clear),
        .step       (trk_step),
        .rx_byte    (in_byte_reg),
        .marker     (MODEL_MARKER),
        .marker_len (MODEL_MARK_LEN),
        .status     (md_status)
    );

    // report: leading-digit value plus model and sentinel checks
    always_comb begin
        kind_val = KIND_UNKNOWN;
        if (md_status.done && match4(md_status.chars, md_status.len, MODEL_SHORT)) begin
            kind_val = KIND_SHORT;
        end else if (md_status.done && match4(md_status.chars, md_status.len, MODEL_LONG)) begin
            kind_val = KIND_LONG;
        end

        depth_val = 14'd0;
        digit_run = 1'b1;
        c         = 8'd0;
        for (int i = 0; i < CAP_MAX; i++) begin
            c = rd_status.chars[i];
            if (digit_run && (3'(i) < rd_status.len) && (c >= "0") && (c <= "9")) begin
                depth_val = 14'(depth_val * 14'd10) + {6'd0, 8'(c - "0")};
            end else begin
                digit_run = 1'b0;
            end
        end

        if (!rd_status.done) begin
            err_val = ERR_NO_READING;
        end else if (kind_val == KIND_UNKNOWN) begin
            err_val = ERR_MODEL;
        end else if ((kind_val == KIND_SHORT) &&
                     match4(rd_status.chars, rd_status.len, SENTINEL_SHORT)) begin
            err_val = ERR_MODEL;
        end else if ((kind_val == KIND_LONG) &&
                     match4(rd_status.chars, rd_status.len, SENTINEL_LONG)) begin
            err_val = ERR_MODEL;
        end else begin
            err_val = ERR_NONE;
        end
        if (err_val != ERR_NONE) begin
            depth_val = 14'd0;
        end
    end

    always_comb begin
        if (s_valid && s_ready) begin
            in_valid_next = 1'b1;
        end else if (fire) begin
            in_valid_next = 1'b0;
        end else begin
            in_valid_next = in_valid_reg;
        end
        if (out_load) begin
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end else begin
            m_valid_next = m_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
            m_valid_reg  <= 1'b0;
        end else begin
            in_valid_reg <= in_valid_next;
            m_valid_reg  <= m_valid_next;
        end
        if (s_valid && s_ready) begin
            in_action_reg <= action_t'(s_action);
            in_byte_reg   <= s_rx_byte;
        end
        if (out_load) begin
            depth_reg <= depth_val;
            err_reg   <= err_val;
            kind_reg  <= kind_val;
        end
    end

    assign m_valid      = m_valid_reg;
    assign m_depth_mm   = depth_reg;
    assign m_error_code = err_reg;
    assign m_model_kind = kind_reg;

`include "sonar_serial_depth_parser_assert.svh"

    `SDP_ASSERT_NOW(a_load_slot_free, aclk, aresetn, out_load, (!m_valid_reg || m_ready))
    `SDP_ASSERT_NOW(a_err_zero_depth, aclk, aresetn, (m_valid && (m_error_code != ERR_NONE)), (m_depth_mm == 14'd0))
    `SDP_ASSERT_NEXT(a_report_shown, aclk, aresetn, out_load, m_valid)
    `SDP_ASSERT_NOW(a_stall_only_report, aclk, aresetn, (in_valid_reg && !fire), (in_action_reg == ACT_REPORT))

endmodule

[tb/sonar_serial_depth_parser_test.sv]
module sonar_serial_depth_parser_test;
    timeunit 1ns;
    timeprecision 1ps;

    import sdp_pkg::*;

    localparam logic [1:0] ACT_UNUSED = 2'd3;
    localparam logic [7:0] CR_BYTE = 8'h0D;
    localparam int unsigned QUIET_LIMIT = 1000;

    localparam logic [0:6][7:0] READING_TAG = {"TempI", 8'h0D, "R"};
    localparam logic [0:6][7:0] MODEL_TAG = {"PN:MB", 16'h0000};
    localparam logic [0:3][7:0] SHORT_ID = "7384";
    localparam logic [0:3][7:0] LONG_ID = "7383";
    localparam logic [0:3][7:0] SHORT_OUT_OF_RANGE = "5000";
    localparam logic [0:3][7:0] LONG_OUT_OF_RANGE = "9999";

    typedef struct packed {
        logic [2:0]       pos;
        phase_t           phase;
        logic [0:3][7:0]  text;
        logic [2:0]       count;
    } tracker_t;

    typedef struct packed {
        logic [13:0] depth;
        err_t        err;
        kind_t       kind;
    } depth_report_t;

    typedef struct packed {
        logic [1:0] act;
        logic [7:0] data;
    } beat_t;

    logic        aclk = 1'b0;
    logic        aresetn;
    logic        s_valid;
    logic        s_ready;
    logic [1:0]  s_action;
    logic [7:0]  s_rx_byte;
    logic        m_valid;
    logic        m_ready;
    logic [13:0] m_depth_mm;
    logic [1:0]  m_error_code;
    logic [1:0]  m_model_kind;

    tracker_t      reading_trk = '0;
    tracker_t      model_trk = '0;
    depth_report_t pending_reports[$];
    depth_report_t want;
    beat_t         session_beats[$];
    bit            idling = 1'b0;
    int            mismatches = 0;
    int            counted_beats = 0;
    int            reports_sent = 0;
    int unsigned   quiet_cycles = 0;

    sonar_serial_depth_parser dut (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .s_valid      (s_valid),
        .s_ready      (s_ready),
        .s_action     (s_action),
        .s_rx_byte    (s_rx_byte),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_depth_mm   (m_depth_mm),
        .m_error_code (m_error_code),
        .m_model_kind (m_model_kind)
    );

    always #2 aclk = ~aclk;

    // ---------------------------------------------------------------- predictor

    function automatic tracker_t advance_tracker(tracker_t t, logic [7:0] b,
                                                 logic [0:6][7:0] tag, int unsigned tag_len);
        if (t.phase == PH_SEARCH) begin
            if (t.pos < tag_len && b == tag[t.pos]) begin
                t.pos = t.pos + 3'd1;
            end else begin
                // first tag char never recurs inside the tag, so restart there
                t.pos = (b == tag[0]) ? 3'd1 : 3'd0;
            end
            if (t.pos >= tag_len) begin
                t.phase = PH_CAPTURE;
                t.pos = 3'd0;
            end
        end else if (t.phase == PH_CAPTURE) begin
            if (b == CR_BYTE) begin
                t.phase = PH_DONE;
            end else if (t.count < 3'd4) begin
                t.text[t.count] = b;
                t.count = t.count + 3'd1;
            end
        end
        return t;
    endfunction

    function automatic depth_report_t compute_depth_report(tracker_t rd, tracker_t md);
        depth_report_t r;
        logic [13:0]   value;
        bit            digits_open;
        r.kind = KIND_UNKNOWN;
        if (md.phase == PH_DONE && md.count == 3'd4) begin
            if (md.text == SHORT_ID) r.kind = KIND_SHORT;
            else if (md.text == LONG_ID) r.kind = KIND_LONG;
        end
        value = '0;
        digits_open = 1'b1;
        for (int i = 0; i < 4; i++) begin
            if (digits_open && i < rd.count && rd.text[i] >= "0" && rd.text[i] <= "9")
                value = value * 14'd10 + 14'(rd.text[i] - "0");
            else
                digits_open = 1'b0;
        end
        if (rd.phase != PH_DONE)
            r.err = ERR_NO_READING;
        else if (r.kind == KIND_UNKNOWN)
            r.err = ERR_MODEL;
        else if (r.kind == KIND_SHORT && rd.count == 3'd4 && rd.text == SHORT_OUT_OF_RANGE)
            r.err = ERR_MODEL;
        else if (r.kind == KIND_LONG && rd.count == 3'd4 && rd.text == LONG_OUT_OF_RANGE)
            r.err = ERR_MODEL;
        else
            r.err = ERR_NONE;
        r.depth = (r.err == ERR_NONE) ? value : 14'd0;
        return r;
    endfunction

    function automatic void apply_beat(beat_t bt);
        case (bt.act)
            ACT_START: begin
                reading_trk = '0;
                model_trk = '0;
            end
            ACT_BYTE: begin
                if (bt.data != 8'h00) begin
                    reading_trk = advance_tracker(reading_trk, bt.data, READING_TAG, 7);
                    model_trk = advance_tracker(model_trk, bt.data, MODEL_TAG, 5);
                end
            end
            ACT_REPORT: pending_reports.push_back(compute_depth_report(reading_trk, model_trk));
            default: ;
        endcase
    endfunction

    // ---------------------------------------------------------------- drivers

    task automatic send_beat(logic [1:0] act, logic [7:0] data);
        beat_t bt;
        bt.act = act;
        bt.data = data;
        if (idling && $urandom_range(0, 5) == 0) begin
            s_valid <= 1'b0;
            repeat ($urandom_range(1, 14)) @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_action <= act;
        s_rx_byte <= data;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        apply_beat(bt);
        if (act == ACT_REPORT) reports_sent++;
        counted_beats++;
    endtask

    task automatic send_text(string s);
        for (int i = 0; i < s.len(); i++) send_beat(ACT_BYTE, s[i]);
    endtask

    initial begin
        m_ready <= 1'b0;
        while (aresetn !== 1'b1) @(posedge aclk);
        forever begin
            if (idling && $urandom_range(0, 7) == 0) begin
                m_ready <= 1'b0;
                repeat ($urandom_range(1, 14)) @(posedge aclk);
            end
            m_ready <= 1'b1;
            @(posedge aclk);
        end
    end

    // ---------------------------------------------------------------- checking

    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) begin
            if (pending_reports.size() == 0) begin
                $error("report beat with none pending: depth_mm %0d error_code %0d model_kind %0d",
                       m_depth_mm, m_error_code, m_model_kind);
                mismatches++;
            end else begin
                want = pending_reports.pop_front();
                if (m_depth_mm !== want.depth) begin
                    $error("depth_mm: expected %0d, got %0d", want.depth, m_depth_mm);
                    mismatches++;
                end
                if (m_error_code !== want.err) begin
                    $error("error_code: expected %0d, got %0d", want.err, m_error_code);
                    mismatches++;
                end
                if (m_model_kind !== want.kind) begin
                    $error("model_kind: expected %0d, got %0d", want.kind, m_model_kind);
                    mismatches++;
                end
            end
        end
    end

    always @(posedge aclk) begin
        if (aresetn) begin
            if ((s_valid && s_ready) || (m_valid && m_ready))
                quiet_cycles <= 0;
            else
                quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles >= QUIET_LIMIT) begin
                $display("tb: failure");
                $finish;
            end
        end
    end

    // ---------------------------------------------------------------- session builder

    function automatic void queue_byte(logic [7:0] b);
        // stray zero bytes must not disturb a partial tag match
        if ($urandom_range(0, 11) == 0) session_beats.push_back('{ACT_BYTE, 8'h00});
        session_beats.push_back('{ACT_BYTE, b});
    endfunction

    function automatic void queue_text(string s);
        for (int i = 0; i < s.len(); i++) queue_byte(s[i]);
    endfunction

    function automatic void queue_digits(int n);
        for (int i = 0; i < n; i++) queue_byte("0" + 8'($urandom_range(0, 9)));
    endfunction

    function automatic void queue_noise(int n);
        for (int i = 0; i < n; i++) queue_byte(8'($urandom_range(0, 255)));
    endfunction

    function automatic void queue_tag(string tag);
        int n;
        if ($urandom_range(0, 4) == 0) begin
            n = $urandom_range(1, tag.len() - 1);
            for (int i = 0; i < n; i++) queue_byte(tag[i]);
            queue_byte(8'($urandom_range(1, 255)));
        end
        queue_text(tag);
    endfunction

    function automatic void queue_reading_field();
        case ($urandom_range(0, 8))
            0: queue_text("5000");
            1: queue_text("9999");
            2, 3: queue_digits(4);
            4: queue_digits($urandom_range(0, 3));
            5: begin
                queue_digits($urandom_range(0, 3));
                queue_byte(8'($urandom_range(58, 255)));
                queue_digits($urandom_range(0, 2));
            end
            6: queue_text("-9999");
            7: queue_digits($urandom_range(5, 7));
            default: queue_noise($urandom_range(1, 5));
        endcase
        if ($urandom_range(0, 7) != 0) queue_byte(CR_BYTE);
    endfunction

    function automatic void queue_model_field();
        case ($urandom_range(0, 7))
            0, 1, 2: queue_text("7384");
            3, 4, 5: queue_text("7383");
            6: begin
                // overlong id: trailing chars are dropped
                queue_text($urandom_range(0, 1) ? "7384" : "7383");
                queue_digits($urandom_range(1, 3));
            end
            default: begin
                if ($urandom_range(0, 1)) queue_digits($urandom_range(0, 5));
                else queue_noise($urandom_range(1, 5));
            end
        endcase
        if ($urandom_range(0, 7) != 0) queue_byte(CR_BYTE);
    endfunction

    function automatic void build_session();
        bit reading_first;
        session_beats.delete();
        if ($urandom_range(0, 9) != 0)
            session_beats.push_back('{ACT_START, 8'($urandom_range(0, 255))});
        queue_noise($urandom_range(0, 3));
        reading_first = 1'($urandom_range(0, 1));
        for (int k = 0; k < 2; k++) begin
            if ((k == 0) == reading_first) begin
                if ($urandom_range(0, 7) != 0) begin
                    queue_tag("TempI\015R");
                    queue_reading_field();
                end
            end else if ($urandom_range(0, 7) != 0) begin
                queue_tag("PN:MB");
                queue_model_field();
            end
            queue_noise($urandom_range(0, 2));
            if ($urandom_range(0, 3) == 0)
                session_beats.push_back('{ACT_REPORT, 8'($urandom_range(0, 255))});
        end
        // tags after a completed field are ignored
        if ($urandom_range(0, 5) == 0) begin
            queue_tag("TempI\015R");
            queue_reading_field();
        end
        if ($urandom_range(0, 5) == 0) begin
            queue_tag("PN:MB");
            queue_model_field();
        end
        if ($urandom_range(0, 9) == 0)
            session_beats.push_back('{ACT_UNUSED, 8'($urandom_range(0, 255))});
        session_beats.push_back('{ACT_REPORT, 8'($urandom_range(0, 255))});
        if ($urandom_range(0, 5) == 0)
            session_beats.push_back('{ACT_REPORT, 8'($urandom_range(0, 255))});
    endfunction

    task automatic play_session();
        foreach (session_beats[i]) send_beat(session_beats[i].act, session_beats[i].data);
    endtask

    // ---------------------------------------------------------------- tests

    task automatic test_report_after_reset();
        send_beat(ACT_REPORT, 8'hFF);
        send_beat(ACT_UNUSED, 8'h00);
    endtask

    task automatic test_clean_session();
        send_beat(ACT_START, 8'hA5);
        send_text("PN:");
        send_beat(ACT_BYTE, 8'h00);
        send_text("MB7383\015TempI\015R1234\015");
        send_beat(ACT_REPORT, 8'h5A);
        send_beat(ACT_REPORT, 8'h00);
    endtask

    task automatic test_random_sessions(int beat_goal, int report_goal);
        idling = 1'b1;
        while (counted_beats < beat_goal || reports_sent < report_goal) begin
            build_session();
            play_session();
        end
    endtask

    task automatic test_drain_pause();
        for (int n = 0; n < 3; n++) begin
            build_session();
            play_session();
        end
        s_valid <= 1'b0;
        do @(posedge aclk); while (pending_reports.size() != 0);
    endtask

    task automatic test_steady_stream(int beat_goal);
        idling = 1'b0;
        while (counted_beats < beat_goal) begin
            build_session();
            play_session();
        end
    endtask

    initial begin
        aresetn <= 1'b0;
        s_valid <= 1'b0;
        s_action <= ACT_START;
        s_rx_byte <= 8'h00;
        repeat (11) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        test_report_after_reset();
        test_clean_session();
        test_random_sessions(400, 20);
        test_drain_pause();
        test_steady_stream(650);

        s_valid <= 1'b0;
        while (pending_reports.size() != 0) @(posedge aclk);
        repeat (8) @(posedge aclk);
        if (mismatches == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule

[filelist.f]
+incdir+hw/rtl
hw/rtl/sdp_pkg.sv
hw/rtl/sdp_tracker.sv
hw/rtl/sonar_serial_depth_parser.sv
tb/sonar_serial_depth_parser_test.sv
